FILE: rtl/sle_pkg.sv
package sle_pkg;

	// line store geometry
	localparam int LINE_DEPTH_DEF = 32;
	localparam int LEN_W          = 6;
	localparam int CNT_W          = 32;
	localparam int BYTE_W         = 8;

	// result kinds
	localparam logic [1:0] KIND_ECHO   = 2'd0;
	localparam logic [1:0] KIND_LINE   = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// special characters
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	// output byte sources
	localparam logic [2:0] BSEL_ZERO  = 3'd0;
	localparam logic [2:0] BSEL_RX    = 3'd1;
	localparam logic [2:0] BSEL_SPACE = 3'd2;
	localparam logic [2:0] BSEL_BS    = 3'd3;
	localparam logic [2:0] BSEL_LF    = 3'd4;
	localparam logic [2:0] BSEL_STORE = 3'd5;

	// microprogram addresses
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] PC_IDLE        = 5'd0;
	localparam logic [PC_W-1:0] PC_ERR_CNT     = 5'd1;
	localparam logic [PC_W-1:0] PC_ERR_STAT    = 5'd2;
	localparam logic [PC_W-1:0] PC_CNT_ONLY    = 5'd3;
	localparam logic [PC_W-1:0] PC_CH_CNT      = 5'd4;
	localparam logic [PC_W-1:0] PC_CH_ECHO     = 5'd5;
	localparam logic [PC_W-1:0] PC_CH_STORE    = 5'd6;
	localparam logic [PC_W-1:0] PC_CHQ_CNT     = 5'd7;
	localparam logic [PC_W-1:0] PC_ESC_CNT     = 5'd9;
	localparam logic [PC_W-1:0] PC_ESC_ECHO    = 5'd10;
	localparam logic [PC_W-1:0] PC_BS_CNT      = 5'd11;
	localparam logic [PC_W-1:0] PC_BS_ECHO     = 5'd12;
	localparam logic [PC_W-1:0] PC_BS_DEC      = 5'd13;
	localparam logic [PC_W-1:0] PC_BS_SPACE    = 5'd14;
	localparam logic [PC_W-1:0] PC_BS_BS       = 5'd15;
	localparam logic [PC_W-1:0] PC_BSQ_DEC     = 5'd16;
	localparam logic [PC_W-1:0] PC_CR_CNT      = 5'd17;
	localparam logic [PC_W-1:0] PC_CR_ECHO     = 5'd18;
	localparam logic [PC_W-1:0] PC_CR_LF       = 5'd19;
	localparam logic [PC_W-1:0] PC_CR_LINE     = 5'd20;
	localparam logic [PC_W-1:0] PC_CR_LOOP     = 5'd21;
	localparam logic [PC_W-1:0] PC_CR_END      = 5'd22;
	localparam logic [PC_W-1:0] PC_CRQ_CNT     = 5'd23;

	// one control word of the microprogram
	typedef struct packed {
		logic            emit;
		logic [1:0]      kind;
		logic [2:0]      bsel;
		logic            last;
		logic            loop;
		logic            inc_chars;
		logic            inc_lines;
		logic            inc_err;
		logic            len_dec;
		logic            store;
		logic            len_clr;
		logic            idx_clr;
		logic [PC_W-1:0] next;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		ucode_t uw;
		logic   fire;
		logic   emit;
		logic   idx_inc;
		logic   accept;
	} dp_ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic loop_end;
		logic slot_free;
		logic echo;
	} dp_stat_t;

	// microprogram table
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '0;
		unique case (pc)
			PC_ERR_CNT: begin
				w.inc_err = 1'b1;
				w.next    = PC_ERR_STAT;
			end
			PC_ERR_STAT: begin
				w.emit = 1'b1; w.kind = KIND_STATUS; w.bsel = BSEL_ZERO; w.last = 1'b1;
				w.next = PC_IDLE;
			end
			PC_CNT_ONLY: begin
				w.inc_chars = 1'b1;
				w.next      = PC_IDLE;
			end
			PC_CH_CNT: begin
				w.inc_chars = 1'b1;
				w.next      = PC_CH_ECHO;
			end
			PC_CH_ECHO: begin
				w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = BSEL_RX; w.last = 1'b1;
				w.next = PC_CH_STORE;
			end
			PC_CH_STORE: begin
				w.store = 1'b1;
				w.next  = PC_IDLE;
			end
			PC_CHQ_CNT: begin
				w.inc_chars = 1'b1;
				w.next      = PC_CH_STORE;
			end
			PC_ESC_CNT: begin
				w.inc_chars = 1'b1;
				w.next      = PC_ESC_ECHO;
			end
			PC_ESC_ECHO: begin
				w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = BSEL_RX; w.last = 1'b1;
				w.next = PC_IDLE;
			end
			PC_BS_CNT: begin
				w.inc_chars = 1'b1;
				w.next      = PC_BS_ECHO;
			end
			PC_BS_ECHO: begin
				w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = BSEL_RX;
				w.next = PC_BS_DEC;
			end
			PC_BS_DEC: begin
				w.len_dec = 1'b1;
				w.next    = PC_BS_SPACE;
			end
			PC_BS_SPACE: begin
				w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = BSEL_SPACE;
				w.next = PC_BS_BS;
			end
			PC_BS_BS: begin
				w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = BSEL_BS; w.last = 1'b1;
				w.next = PC_IDLE;
			end
			PC_BSQ_DEC: begin
				w.inc_chars = 1'b1;
				w.len_dec   = 1'b1;
				w.next      = PC_IDLE;
			end
			PC_CR_CNT: begin
				w.inc_chars = 1'b1;
				w.next      = PC_CR_ECHO;
			end
			PC_CR_ECHO: begin
				w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = BSEL_RX;
				w.next = PC_CR_LF;
			end
			PC_CR_LF: begin
				w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = BSEL_LF;
				w.next = PC_CR_LINE;
			end
			PC_CR_LINE: begin
				w.inc_lines = 1'b1;
				w.idx_clr   = 1'b1;
				w.next      = PC_CR_LOOP;
			end
			PC_CR_LOOP: begin
				w.emit = 1'b1; w.kind = KIND_LINE; w.bsel = BSEL_STORE; w.loop = 1'b1;
				w.next = PC_CR_END;
			end
			PC_CR_END: begin
				w.emit = 1'b1; w.kind = KIND_END; w.bsel = BSEL_ZERO; w.last = 1'b1;
				w.len_clr = 1'b1;
				w.next    = PC_IDLE;
			end
			PC_CRQ_CNT: begin
				w.inc_chars = 1'b1;
				w.inc_lines = 1'b1;
				w.idx_clr   = 1'b1;
				w.next      = PC_CR_LOOP;
			end
			default: begin
				w.next = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/sle_ram.sv
module sle_ram
	import sle_pkg::*;
#(
	parameter int WIDTH = BYTE_W,
	parameter int DEPTH = LINE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/sle_useq.sv
module sle_useq
	import sle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_func,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              in_ready,
	input  dp_stat_t          stat,
	output dp_ctrl_t          ctrl
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic [PC_W-1:0] entry;
	logic            idle;
	logic            accept;
	logic            emit_req;
	logic            fire;
	ucode_t          uw;

	assign idle     = (pc_q == PC_IDLE);
	assign in_ready = idle;
	assign accept   = in_valid && idle;
	assign uw       = ucode_rom(pc_q);

	// entry point from the item's class and the echo setting
	always_comb begin
		priority if (in_func) begin
			entry = PC_ERR_CNT;
		end else if (in_byte == CH_LF) begin
			entry = PC_CNT_ONLY;
		end else if (in_byte == CH_BS) begin
			entry = stat.echo ? PC_BS_CNT : PC_BSQ_DEC;
		end else if (in_byte == CH_ESC) begin
			entry = stat.echo ? PC_ESC_CNT : PC_CNT_ONLY;
		end else if (in_byte == CH_CR) begin
			entry = stat.echo ? PC_CR_CNT : PC_CRQ_CNT;
		end else begin
			entry = stat.echo ? PC_CH_CNT : PC_CHQ_CNT;
		end
	end

	// a step with a result waits for the output slot
	assign emit_req = uw.emit && !(uw.loop && stat.loop_end);
	assign fire     = !idle && (!emit_req || stat.slot_free);

	// next step
	always_comb begin
		if (idle) begin
			pc_d = accept ? entry : PC_IDLE;
		end else if (!fire) begin
			pc_d = pc_q;
		end else if (uw.loop && !stat.loop_end) begin
			pc_d = pc_q;
		end else begin
			pc_d = uw.next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign ctrl.uw      = uw;
	assign ctrl.fire    = fire;
	assign ctrl.emit    = fire && emit_req;
	assign ctrl.idx_inc = fire && uw.loop && !stat.loop_end;
	assign ctrl.accept  = accept;

endmodule

FILE: rtl/sle_dpath.sv
module sle_dpath
	import sle_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_ctrl_t          ctrl,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              cfg_valid,
	input  logic              cfg_data,
	output dp_stat_t          stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_kind,
	output logic              out_last,
	output logic [BYTE_W-1:0] out_byte,
	output logic [LEN_W-1:0]  out_len,
	output logic [CNT_W-1:0]  out_chars,
	output logic [CNT_W-1:0]  out_lines,
	output logic [CNT_W-1:0]  out_lost,
	output logic [CNT_W-1:0]  out_errors
);

	localparam int AW = $clog2(LINE_DEPTH);

	logic              echo_q;
	logic [BYTE_W-1:0] rx_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  idx_q;
	logic [LEN_W-1:0]  idx_d;
	logic [CNT_W-1:0]  chars_q;
	logic [CNT_W-1:0]  lines_q;
	logic [CNT_W-1:0]  lost_q;
	logic [CNT_W-1:0]  errors_q;
	logic              room;
	logic              wr_en;
	logic [BYTE_W-1:0] rd_data;
	logic [BYTE_W-1:0] byte_mux;
	logic              ovalid_q;
	logic              slot_free;

	assign room      = (len_q < LEN_W'(LINE_DEPTH));
	assign wr_en     = ctrl.fire && ctrl.uw.store && room;
	assign slot_free = !ovalid_q || out_ready;

	// echo register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_q <= 1'b1;
		end else if (cfg_valid) begin
			echo_q <= cfg_data;
		end
	end

	// latched item byte
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			rx_q <= in_byte;
		end
	end

	// line length and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			chars_q  <= '0;
			lines_q  <= '0;
			lost_q   <= '0;
			errors_q <= '0;
		end else if (ctrl.fire) begin
			if (ctrl.uw.inc_chars) begin
				chars_q <= chars_q + 1'b1;
			end
			if (ctrl.uw.inc_lines) begin
				lines_q <= lines_q + 1'b1;
			end
			if (ctrl.uw.inc_err) begin
				errors_q <= errors_q + 1'b1;
			end
			if (ctrl.uw.store && !room) begin
				lost_q <= lost_q + 1'b1;
			end
			priority if (ctrl.uw.len_clr) begin
				len_q <= '0;
			end else if (ctrl.uw.len_dec && (len_q != '0)) begin
				len_q <= len_q - 1'b1;
			end else if (ctrl.uw.store && room) begin
				len_q <= len_q + 1'b1;
			end
		end
	end

	// read index; the store is read at the next index so data lines up
	always_comb begin
		priority if (ctrl.fire && ctrl.uw.idx_clr) begin
			idx_d = '0;
		end else if (ctrl.idx_inc) begin
			idx_d = idx_q + 1'b1;
		end else begin
			idx_d = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			idx_q <= idx_d;
		end
	end

	sle_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(LINE_DEPTH)
	) u_line_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(len_q[AW-1:0]),
		.wdata(rx_q),
		.raddr(idx_d[AW-1:0]),
		.rdata(rd_data)
	);

	// result byte source
	always_comb begin
		unique case (ctrl.uw.bsel)
			BSEL_RX:    byte_mux = rx_q;
			BSEL_SPACE: byte_mux = CH_SPACE;
			BSEL_BS:    byte_mux = CH_BS;
			BSEL_LF:    byte_mux = CH_LF;
			BSEL_STORE: byte_mux = rd_data;
			default:    byte_mux = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ctrl.emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_kind   <= ctrl.uw.kind;
			out_last   <= ctrl.uw.last;
			out_byte   <= byte_mux;
			out_len    <= len_q;
			out_chars  <= chars_q;
			out_lines  <= lines_q;
			out_lost   <= lost_q;
			out_errors <= errors_q;
		end
	end

	assign out_valid      = ovalid_q;
	assign stat.loop_end  = (idx_q == len_q);
	assign stat.slot_free = slot_free;
	assign stat.echo      = echo_q;

endmodule

FILE: rtl/serial_line_editor_unit.sv
// an item is taken in the idle cycle; its first result, if any, is registered by a later step of its sequence
// items are handled one at a time: a new item is taken only once the previous item's steps have
// run back to idle; a carriage return also reads the stored line out, one line byte per cycle
// while the output slot is free
// the microprogram step counter sets the order of steps; a stalled output holds the step in place
// reset: counters and line length clear, echo turns on, line store contents stay undefined
module serial_line_editor_unit
	import sle_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // rx_byte
	input  logic         s_tuser,   // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // out_byte, line_length, total_chars, total_lines,
	                                // lost_chars, rx_errors, zero fill
	output logic [1:0]   m_tuser,   // result_kind
	output logic         m_tlast,   // last_of_run
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data   // echo_enable
);

	dp_ctrl_t          ctrl;
	dp_stat_t          stat;
	logic [BYTE_W-1:0] o_byte;
	logic [LEN_W-1:0]  o_len;
	logic [CNT_W-1:0]  o_chars;
	logic [CNT_W-1:0]  o_lines;
	logic [CNT_W-1:0]  o_lost;
	logic [CNT_W-1:0]  o_errors;

	assign cfg_ready = 1'b1;

	// step counter and control table
	sle_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_func (s_tuser),
		.in_byte (s_tdata),
		.in_ready(s_tready),
		.stat    (stat),
		.ctrl    (ctrl)
	);

	// line store, counters and output register
	sle_dpath #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_byte   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_last  (m_tlast),
		.out_byte  (o_byte),
		.out_len   (o_len),
		.out_chars (o_chars),
		.out_lines (o_lines),
		.out_lost  (o_lost),
		.out_errors(o_errors)
	);

	// result packing, lowest field first
	assign m_tdata = {2'b00, o_errors, o_lost, o_lines, o_chars, o_len, o_byte};

endmodule

FILE: sim/serial_line_editor_unit_tb.sv
module serial_line_editor_unit_tb
	import sle_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic FUNC_BYTE  = 1'b0;
	localparam logic FUNC_RXERR = 1'b1;

	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 12;
	localparam int STALL_LIMIT  = 2000;

	// one expected result
	typedef struct {
		logic [1:0]       kind;
		logic [BYTE_W-1:0] out_byte;
		logic [LEN_W-1:0] line_length;
		logic             last;
		logic [CNT_W-1:0] total_chars;
		logic [CNT_W-1:0] total_lines;
		logic [CNT_W-1:0] lost_chars;
		logic [CNT_W-1:0] rx_errors;
	} editor_result_t;

	// line editor prediction and result comparison
	class line_editor_scoreboard;
		logic              echo_on;
		logic [BYTE_W-1:0] line_buf [LINE_DEPTH_DEF];
		int                line_len;
		logic [CNT_W-1:0]  chars, lines, lost, errs;
		editor_result_t    expected_q[$];
		int                fails;
		int                checked;

		function new();
			echo_on  = 1'b1;
			line_len = 0;
			chars    = '0;
			lines    = '0;
			lost     = '0;
			errs     = '0;
			fails    = 0;
			checked  = 0;
		endfunction

		function void add(logic [1:0] kind, logic [BYTE_W-1:0] b);
			editor_result_t r;
			r.kind        = kind;
			r.out_byte    = b;
			r.line_length = LEN_W'(line_len);
			r.last        = 1'b0;
			r.total_chars = chars;
			r.total_lines = lines;
			r.lost_chars  = lost;
			r.rx_errors   = errs;
			expected_q.push_back(r);
		endfunction

		// work out the results one accepted item causes
		function void note_input(logic func, logic [BYTE_W-1:0] b);
			int n0;
			n0 = expected_q.size();
			if (func == FUNC_RXERR) begin
				errs++;
				add(KIND_STATUS, '0);
			end else begin
				chars++;
				if (b != CH_LF) begin
					if (echo_on)
						add(KIND_ECHO, b);
					if (b == CH_BS) begin
						if (line_len > 0)
							line_len--;
						if (echo_on) begin
							add(KIND_ECHO, CH_SPACE);
							add(KIND_ECHO, CH_BS);
						end
					end else if (b == CH_ESC) begin
						// escape only echoes
					end else if (b == CH_CR) begin
						if (echo_on)
							add(KIND_ECHO, CH_LF);
						lines++;
						for (int i = 0; i < line_len; i++)
							add(KIND_LINE, line_buf[i]);
						add(KIND_END, '0);
						line_len = 0;
					end else if (line_len < LINE_DEPTH_DEF) begin
						line_buf[line_len] = b;
						line_len++;
					end else begin
						lost++;
					end
				end
			end
			if (expected_q.size() > n0)
				expected_q[expected_q.size()-1].last = 1'b1;
		endfunction

		function void cmp(string name, logic [CNT_W-1:0] e, logic [CNT_W-1:0] a);
			if (a !== e) begin
				$error("%s: expected %0h, got %0h", name, e, a);
				fails++;
			end
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(logic [1:0] kind, logic [143:0] d, logic last);
			editor_result_t e;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: kind %0d data %0h", kind, d);
				fails++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			cmp("result_kind", e.kind, kind);
			cmp("out_byte", e.out_byte, d[7:0]);
			cmp("line_length", e.line_length, d[13:8]);
			cmp("last_of_run", e.last, last);
			cmp("total_chars", e.total_chars, d[45:14]);
			cmp("total_lines", e.total_lines, d[77:46]);
			cmp("lost_chars", e.lost_chars, d[109:78]);
			cmp("rx_errors", e.rx_errors, d[141:110]);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_data;

	line_editor_scoreboard sb;
	int items_sent;
	int hold_seq;
	bit tight;

	serial_line_editor_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: check accepted items, stall at random or for a long hold-off
	initial begin
		int stall_left;
		int hold_seen;
		stall_left = 0;
		hold_seen  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata, m_tlast);
			if (hold_seen != hold_seq) begin
				hold_seen  = hold_seq;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!tight && $urandom_range(0, 3) == 0) begin
				stall_left = idle_gap();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake at all
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// offer one item, keeping tvalid high across back-to-back items
	task automatic send_item(input logic func, input logic [7:0] b);
		int gap;
		gap = tight ? 0 : idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_input(func, b);
		if (!(func == FUNC_BYTE && b == CH_LF))
			items_sent++;
	endtask

	task automatic send_char(input logic [7:0] b);
		send_item(FUNC_BYTE, b);
	endtask

	// wait for every expected result, then let a silent item finish
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_echo(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.echo_on = v;
	endtask

	// one line of random content, mostly closed by a carriage return
	task automatic type_line(input int len, input bit close);
		int r;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 6)
				send_char(CH_BS);
			else if (r < 9)
				send_char(CH_ESC);
			else if (r < 11)
				send_char(CH_LF);
			else if (r < 14)
				send_item(FUNC_RXERR, 8'($urandom_range(0, 255)));
			else if (r < 24)
				send_char(8'($urandom_range(0, 255)));
			else
				send_char(8'($urandom_range(8'h20, 8'h7E)));
		end
		if (close)
			send_char(CH_CR);
	endtask

	task automatic random_lines(input int target);
		int start;
		int r;
		int len;
		start = items_sent;
		while (items_sent - start < target) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(0, 12);
			else if (r < 92)
				len = $urandom_range(13, 32);
			else
				len = $urandom_range(33, 40);
			type_line(len, $urandom_range(0, 19) != 0);
		end
	endtask

	// stimulus
	initial begin
		sb         = new();
		items_sent = 0;
		hold_seq   = 0;
		tight      = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		m_tready   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, echo on: extremes, editing keys, errors, empty lines
		write_echo(1'b1);
		send_char(8'h41);
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h7F);
		send_char(CH_BS);
		send_char(CH_ESC);
		send_char(CH_LF);
		send_item(FUNC_RXERR, 8'hA5);
		send_char(CH_CR);
		send_char(CH_CR);
		send_char(CH_BS);
		send_item(FUNC_RXERR, 8'h5A);
		drain();

		// directed, echo off: silent items and backspace on an empty line
		write_echo(1'b0);
		send_char(8'h78);
		send_char(CH_BS);
		send_char(CH_BS);
		send_char(CH_ESC);
		send_char(CH_LF);
		send_char(8'h80);
		send_char(CH_CR);
		send_item(FUNC_RXERR, 8'hFF);
		send_char(CH_CR);
		drain();

		// overflowing line while the result side holds off
		write_echo(1'b1);
		hold_seq <= hold_seq + 1;
		for (int i = 0; i < 36; i++)
			send_char(8'h30 + 8'(i));
		send_char(CH_CR);
		random_lines(50);
		drain();

		write_echo(1'b0);
		random_lines(55);
		drain();

		// back to back, no idling on either side
		write_echo(1'b1);
		tight = 1'b1;
		random_lines(50);
		tight = 1'b0;
		drain();

		$display("tb: %0d items, %0d results checked, %0d lines, %0d bytes lost to a full line",
			items_sent, sb.checked, sb.lines, sb.lost);
		$display("tb: echo on and off, receive errors, result hold-off and back-to-back traffic");
		if (sb.fails == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
